// ===== design/hotp_code_generator_macros.svh =====
// Assertion helpers for the HOTP generator.
`ifndef HOTP_CODE_GENERATOR_MACROS_SVH
`define HOTP_CODE_GENERATOR_MACROS_SVH

// Same-cycle implication, off during reset.
`define HOTP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define HOTP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/hotp_pkg.sv =====
`timescale 1ns / 1ps
package hotp_pkg;

   localparam int ROUNDS        = 80;
   localparam int KEY_MAX_BYTES = 32;
   localparam int KEY_REG_BYTES = 32;
   localparam int CODE_BITS     = 31;

   typedef logic [4:0][31:0]  state_type;  // [4] = a / h0
   typedef logic [15:0][31:0] win_type;    // [0] = current schedule word

   typedef struct packed {
      logic      ready;
      state_type inner;
      state_type outer;
   } midstate_type;

   localparam logic [2:0] CSR_KEY0   = 3'd0;
   localparam logic [2:0] CSR_KEY1   = 3'd1;
   localparam logic [2:0] CSR_KEY2   = 3'd2;
   localparam logic [2:0] CSR_KEY3   = 3'd3;
   localparam logic [2:0] CSR_KEYLEN = 3'd4;
   localparam logic [2:0] CSR_DIGITS = 3'd5;

   localparam state_type SHA1_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                    32'h10325476, 32'hC3D2E1F0};
   localparam win_type IPAD = {16{32'h36363636}};
   localparam win_type OPAD = {16{32'h5C5C5C5C}};

   function automatic state_type sha1_round(state_type s, logic [31:0] w,
                                            logic [6:0] idx);
      logic [31:0] a, b, c, d, e, f, k, t;
      state_type r;
      a = s[4]; b = s[3]; c = s[2]; d = s[1]; e = s[0];
      if (idx < 7'd20) begin
         f = (b & c) | (~b & d);  k = 32'h5A827999;
      end else if (idx < 7'd40) begin
         f = b ^ c ^ d;           k = 32'h6ED9EBA1;
      end else if (idx < 7'd60) begin
         f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
         f = b ^ c ^ d;           k = 32'hCA62C1D6;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w;
      r[4] = t; r[3] = a; r[2] = {b[1:0], b[31:2]}; r[1] = c; r[0] = d;
      return r;
   endfunction

   function automatic win_type sha1_sched(win_type w);
      logic [31:0] x;
      x = w[13] ^ w[8] ^ w[2] ^ w[0];
      return win_type'({{x[30:0], x[31]}, w[15:1]});
   endfunction

   function automatic state_type sha1_add(state_type a, state_type b);
      state_type r;
      for (int i = 0; i < 5; i++) r[i] = a[i] + b[i];
      return r;
   endfunction

   // Second inner block: counter, pad bit, length 72 bytes
   function automatic win_type inner_block(logic [63:0] ctr);
      win_type w;
      w = '0;
      w[0] = ctr[63:32]; w[1] = ctr[31:0]; w[2] = 32'h80000000; w[15] = 32'd576;
      return w;
   endfunction

   // Second outer block: inner digest, pad bit, length 84 bytes
   function automatic win_type outer_block(state_type d);
      win_type w;
      w = '0;
      w[0] = d[4]; w[1] = d[3]; w[2] = d[2]; w[3] = d[1]; w[4] = d[0];
      w[5] = 32'h80000000; w[15] = 32'd672;
      return w;
   endfunction

   function automatic logic [29:0] pow10(logic [3:0] n);
      logic [29:0] r;
      case (n)
         4'd0: r = 30'd1;
         4'd1: r = 30'd10;
         4'd2: r = 30'd100;
         4'd3: r = 30'd1000;
         4'd4: r = 30'd10000;
         4'd5: r = 30'd100000;
         4'd6: r = 30'd1000000;
         4'd7: r = 30'd10000000;
         4'd8: r = 30'd100000000;
         default: r = 30'd1000000000;
      endcase
      return r;
   endfunction

endpackage

// ===== design/hotp_key_sched.sv =====
`timescale 1ns / 1ps
module hotp_key_sched (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  restart,
   input  logic [255:0]          key,
   input  logic [5:0]            key_length,
   output hotp_pkg::midstate_type mid
);
   import hotp_pkg::*;

   typedef enum logic [2:0] {
      ST_LOAD_IN, ST_RUN_IN, ST_LOAD_OUT, ST_RUN_OUT, ST_DONE
   } phase_type;

   phase_type   state_ff;
   logic [6:0]  cnt_ff;
   state_type   st_ff, mid_i_ff, mid_o_ff, st_in;
   win_type     win_ff, kblock;
   logic [5:0]  klen;

   assign klen = (key_length > 6'(KEY_MAX_BYTES)) ? 6'(KEY_MAX_BYTES) : key_length;

   // zero-padded key block, bytes past the length cleared
   for (genvar b = 0; b < 64; b++) begin : g_kbyte
      if (b < KEY_REG_BYTES) begin : g_reg
         assign kblock[b/4][31-8*(b%4) -: 8] =
            (6'(b) < klen) ? key[255-8*b -: 8] : 8'h00;
      end else begin : g_zero
         assign kblock[b/4][31-8*(b%4) -: 8] = 8'h00;
      end
   end

   assign st_in = sha1_round(st_ff, win_ff[0], cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD_IN;
         cnt_ff   <= '0;
      end else if (restart) begin
         state_ff <= ST_LOAD_IN;
      end else begin
         unique case (state_ff)
            ST_LOAD_IN, ST_LOAD_OUT: begin
               st_ff    <= SHA1_IV;
               win_ff   <= kblock ^ ((state_ff == ST_LOAD_IN) ? IPAD : OPAD);
               cnt_ff   <= '0;
               state_ff <= (state_ff == ST_LOAD_IN) ? ST_RUN_IN : ST_RUN_OUT;
            end
            ST_RUN_IN, ST_RUN_OUT: begin
               st_ff  <= st_in;
               win_ff <= sha1_sched(win_ff);
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'(ROUNDS - 1)) begin
                  if (state_ff == ST_RUN_IN) begin
                     mid_i_ff <= sha1_add(SHA1_IV, st_in);
                     state_ff <= ST_LOAD_OUT;
                  end else begin
                     mid_o_ff <= sha1_add(SHA1_IV, st_in);
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_DONE: state_ff <= ST_DONE;
            default: state_ff <= ST_LOAD_IN;
         endcase
      end
   end

   assign mid.ready = (state_ff == ST_DONE);
   assign mid.inner = mid_i_ff;
   assign mid.outer = mid_o_ff;

endmodule

// ===== design/hotp_sha1_pipe.sv =====
`timescale 1ns / 1ps
module hotp_sha1_pipe (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  hotp_pkg::state_type iv,
   input  hotp_pkg::win_type   block,
   output logic                out_valid,
   output hotp_pkg::state_type out_digest
);
   import hotp_pkg::*;

   logic      vld_ff [0:ROUNDS];
   state_type st_ff  [0:ROUNDS];
   win_type   win_ff [0:ROUNDS-1];
   logic      dvld_ff;
   state_type dig_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= ROUNDS; j++) vld_ff[j] <= 1'b0;
         dvld_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int j = 0; j < ROUNDS; j++) vld_ff[j+1] <= vld_ff[j];
         dvld_ff <= vld_ff[ROUNDS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0]  <= iv;
         win_ff[0] <= block;
         dig_ff    <= sha1_add(iv, st_ff[ROUNDS]);
      end
   end

   // one round per stage
   for (genvar j = 0; j < ROUNDS; j++) begin : g_round
      always_ff @(posedge clock) begin
         if (en) st_ff[j+1] <= sha1_round(st_ff[j], win_ff[j][0], 7'(j));
      end
      if (j < ROUNDS - 1) begin : g_win
         always_ff @(posedge clock) begin
            if (en) win_ff[j+1] <= sha1_sched(win_ff[j]);
         end
      end
   end

   assign out_valid  = dvld_ff;
   assign out_digest = dig_ff;

endmodule

// ===== design/hotp_trunc_mod.sv =====
`timescale 1ns / 1ps
module hotp_trunc_mod (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  hotp_pkg::state_type digest,
   input  logic [29:0]         modulus,
   output logic                out_valid,
   output logic [29:0]         out_password
);
   import hotp_pkg::*;

   logic [159:0]          shifted;
   logic                  vld_ff  [0:CODE_BITS];
   logic [29:0]           rem_ff  [0:CODE_BITS];
   logic [CODE_BITS-1:0]  code_ff [0:CODE_BITS-1];

   // dynamic truncation: offset from low nibble of the last byte
   assign shifted = digest << {digest[0][3:0], 3'b000};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= CODE_BITS; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int k = 0; k < CODE_BITS; k++) vld_ff[k+1] <= vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         code_ff[0] <= shifted[158:128];
         rem_ff[0]  <= '0;
      end
   end

   // restoring remainder, one code bit per stage, MSB first
   for (genvar k = 0; k < CODE_BITS; k++) begin : g_mod
      logic [30:0] trial;
      assign trial = {rem_ff[k], code_ff[k][CODE_BITS-1-k]};
      always_ff @(posedge clock) begin
         if (en) begin
            if (trial >= {1'b0, modulus}) rem_ff[k+1] <= 30'(trial - {1'b0, modulus});
            else                         rem_ff[k+1] <= trial[29:0];
         end
      end
      if (k < CODE_BITS - 1) begin : g_fwd
         always_ff @(posedge clock) begin
            if (en) code_ff[k+1] <= code_ff[k];
         end
      end
   end

   assign out_valid    = vld_ff[CODE_BITS];
   assign out_password = rem_ff[CODE_BITS];

endmodule

// ===== design/hotp_code_generator.sv =====
`timescale 1ns / 1ps
// Datapath: a req transaction passes the inner hash pipe, the outer hash pipe and truncate/mod to rsp_valid.
// Throughput: one counter per cycle; a stall on rsp freezes the whole pipeline in place.
// Key midstates are hashed by an iterative round unit: req_ready stays low until both midstates
// are ready, after reset and after any key or key_length write.
// Reset: synchronous, active high; clears valid bits, key to zero, key_length 20, digits 6.
`include "hotp_code_generator_macros.svh"
module hotp_code_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_counter,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [29:0] rsp_password,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import hotp_pkg::*;

   logic [63:0]  key0_ff, key1_ff, key2_ff, key3_ff;
   logic [5:0]   key_length_ff;
   logic [3:0]   digit_count_ff;
   logic         key_write;
   logic         en;
   logic [29:0]  modulus;
   midstate_type mid;
   logic         inner_valid, outer_valid;
   state_type    inner_digest, outer_digest;

   // CSR decode
   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff        <= '0;
         key1_ff        <= '0;
         key2_ff        <= '0;
         key3_ff        <= '0;
         key_length_ff  <= 6'd20;
         digit_count_ff <= 4'd6;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY0:   key0_ff        <= csr_wdata;
            CSR_KEY1:   key1_ff        <= csr_wdata;
            CSR_KEY2:   key2_ff        <= csr_wdata;
            CSR_KEY3:   key3_ff        <= csr_wdata;
            CSR_KEYLEN: key_length_ff  <= csr_wdata[5:0];
            CSR_DIGITS: digit_count_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // any key-related write invalidates the precomputed midstates
   assign key_write = csr_we && (csr_index == CSR_KEY0 || csr_index == CSR_KEY1 ||
                      csr_index == CSR_KEY2 || csr_index == CSR_KEY3 ||
                      csr_index == CSR_KEYLEN);

   // pow10 saturates digit counts above nine
   assign modulus = pow10(digit_count_ff);

   // global advance: output slot empty or being drained
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en && mid.ready;

   hotp_key_sched u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .restart    (key_write),
      .key        ({key0_ff, key1_ff, key2_ff, key3_ff}),
      .key_length (key_length_ff),
      .mid        (mid)
   );

   // HMAC inner hash, second block only (key block is the midstate)
   hotp_sha1_pipe u_inner (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_valid && req_ready),
      .iv         (mid.inner),
      .block      (inner_block(req_counter)),
      .out_valid  (inner_valid),
      .out_digest (inner_digest)
   );

   // HMAC outer hash over the inner digest
   hotp_sha1_pipe u_outer (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (inner_valid),
      .iv         (mid.outer),
      .block      (outer_block(inner_digest)),
      .out_valid  (outer_valid),
      .out_digest (outer_digest)
   );

   hotp_trunc_mod u_trunc_mod (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (outer_valid),
      .digest       (outer_digest),
      .modulus      (modulus),
      .out_valid    (rsp_valid),
      .out_password (rsp_password)
   );

   `HOTP_ASSERT_IMPL(a_no_req_while_keying, !mid.ready, !req_ready, "req accepted during key setup")
   `HOTP_ASSERT_NEXT(a_key_write_restarts, key_write, !mid.ready, "key write did not restart setup")
   `HOTP_ASSERT_IMPL(a_pw_in_range, rsp_valid, rsp_password < modulus, "password not reduced")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Bench for the HOTP code generator: an HMAC-SHA1 predictor computes the expected
// password for every accepted counter and a scoreboard compares it with each
// rsp transaction in order.
module tb_top;
   import hotp_pkg::*;

   // Expected-password store plus the predictor's copy of the key and digit settings
   class otp_scoreboard;
      bit [63:0] key_word [4];
      bit [5:0]  key_len;
      bit [3:0]  digits;
      bit [29:0] pending_pw [$];
      int        mismatches;

      function new();
         foreach (key_word[i]) key_word[i] = '0;
         key_len    = 6'd20;
         digits     = 4'd6;
         mismatches = 0;
      endfunction

      function void apply_csr(bit [2:0] idx, bit [63:0] data);
         case (idx)
            CSR_KEY0:   key_word[0] = data;
            CSR_KEY1:   key_word[1] = data;
            CSR_KEY2:   key_word[2] = data;
            CSR_KEY3:   key_word[3] = data;
            CSR_KEYLEN: key_len = data[5:0];
            CSR_DIGITS: digits = data[3:0];
            default: ;
         endcase
      endfunction

      // One SHA-1 compression of a 512-bit block into a 160-bit chaining value
      function bit [159:0] sha1_compress(bit [159:0] hv, bit [511:0] blk);
         bit [31:0] w [80];
         bit [31:0] a, b, c, d, e, f, k, t, x;
         for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
         for (int i = 16; i < 80; i++) begin
            x = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
            w[i] = {x[30:0], x[31]};
         end
         {a, b, c, d, e} = hv;
         for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
               f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (i < 40) begin
               f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (i < 60) begin
               f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
               f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i];
            e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
         end
         return {hv[159:128] + a, hv[127:96] + b, hv[95:64] + c, hv[63:32] + d,
                 hv[31:0] + e};
      endfunction

      function bit [29:0] predict_password(bit [63:0] ctr);
         bit [159:0] iv, hv, inner_dig;
         bit [511:0] kpad;
         bit [31:0]  code;
         bit [3:0]   off;
         int         klen, nd;
         bit [31:0]  modulus;
         iv   = 160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
         klen = (key_len > 32) ? 32 : key_len;
         nd   = (digits > 9) ? 9 : digits;
         kpad = '0;
         for (int i = 0; i < klen; i++)
            kpad[511 - 8 * i -: 8] = key_word[i / 8][63 - 8 * (i % 8) -: 8];
         // inner hash: key^ipad, then counter with padding, 72-byte message
         hv = sha1_compress(iv, kpad ^ {64{8'h36}});
         inner_dig = sha1_compress(hv, {ctr, 32'h80000000, 352'b0, 64'd576});
         // outer hash: key^opad, then inner digest with padding, 84-byte message
         hv = sha1_compress(iv, kpad ^ {64{8'h5C}});
         hv = sha1_compress(hv, {inner_dig, 32'h80000000, 256'b0, 64'd672});
         // dynamic truncation
         off  = hv[3:0];
         code = hv[159 - 8 * off -: 32] & 32'h7FFFFFFF;
         modulus = 1;
         for (int i = 0; i < nd; i++) modulus = modulus * 10;
         return 30'(code % modulus);
      endfunction

      function void note_counter(bit [63:0] ctr);
         pending_pw.push_back(predict_password(ctr));
      endfunction

      function void check_password(bit [29:0] pw);
         bit [29:0] want;
         if (pending_pw.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected password %0d with nothing pending", pw);
         end else begin
            want = pending_pw.pop_front();
            if (want !== pw) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: password expected %0d actual %0d", want, pw);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_counter = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [29:0] rsp_password;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_KEY0;
   logic [63:0] csr_wdata = '0;

   otp_scoreboard sb = new();
   bit            hold_request = 1'b0;   // asks the receiver for one long hold-off

   hotp_code_generator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_counter(req_counter),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_password(rsp_password),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // Watchdog: far beyond the slowest legal run
   initial begin
      #4000000;
      $display("Mismatches found");
      $finish;
   end

   // Result side: every accepted rsp transaction goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_password(rsp_password);
   end

   // Receiver: random ready/stall runs, open stretches, and one long hold-off on request
   initial begin : receiver
      int run_len;
      bit level;
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            run_len = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
               0:       level = 1'b0;
               1:       begin level = 1'b1; run_len = run_len * 8; end
               default: level = 1'b1;
            endcase
            rsp_ready <= level;
            for (int i = 0; i < run_len && !hold_request; i++) @(negedge clock);
         end
      end
   end

   // Offer one counter; valid stays up until the transaction completes.
   // Called at a falling edge, returns at a falling edge.
   task automatic send_counter(bit [63:0] ctr);
      req_valid   <= 1'b1;
      req_counter <= ctr;
      do @(posedge clock); while (!req_ready);
      sb.note_counter(ctr);
      @(negedge clock);
   endtask

   task automatic idle_cycles(int n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending_pw.size() != 0) @(negedge clock);
   endtask

   // Register write; only called with the pipeline empty.
   // Write enable drops for one cycle before the next write.
   task automatic write_csr(bit [2:0] idx, bit [63:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.apply_csr(idx, data);
      @(negedge clock);
   endtask

   task automatic set_key(bit [63:0] k0, k1, k2, k3, bit [5:0] len, bit [3:0] nd);
      write_csr(CSR_KEY0, k0);
      write_csr(CSR_KEY1, k1);
      write_csr(CSR_KEY2, k2);
      write_csr(CSR_KEY3, k3);
      write_csr(CSR_KEYLEN, {58'b0, len});
      write_csr(CSR_DIGITS, {60'b0, nd});
      @(negedge clock);
   endtask

   function automatic bit [63:0] random_counter();
      case ($urandom_range(0, 5))
         0:       return 64'($urandom_range(0, 255));          // low HOTP counters
         1:       return ~64'($urandom_range(0, 255));         // near the top
         2:       return 64'($urandom) & 64'h0000_0000_FFFF_FFFF;  // TOTP-like steps
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Bursts of back-to-back counters separated by random gaps unless no_gaps is set
   task automatic send_bursts(int n, bit no_gaps);
      int burst_left;
      burst_left = $urandom_range(1, 40);
      for (int i = 0; i < n; i++) begin
         send_counter(random_counter());
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (!no_gaps) idle_cycles($urandom_range(1, 20));
         end
      end
   endtask

   initial begin : stimulus
      bit [63:0] edge_ctrs [8];
      edge_ctrs = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 64'h8000_0000_0000_0000,
                    64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                    64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: all-zero key of 20 bytes, 6 digits
      foreach (edge_ctrs[i]) send_counter(edge_ctrs[i]);
      wait_drained();

      // Standard 20-byte ASCII test key, counters 0..9
      set_key(64'h3132333435363738, 64'h3930313233343536, 64'h3738393000000000, 64'h0,
              6'd20, 4'd6);
      for (int i = 0; i < 10; i++) send_counter(64'(i));
      wait_drained();

      // Digit count extremes: zero gives modulus one, above nine saturates
      write_csr(CSR_DIGITS, 64'd0);
      send_counter(64'd3);
      send_counter(64'hFFFF_FFFF_FFFF_FFFF);
      wait_drained();
      write_csr(CSR_DIGITS, 64'd15);
      send_counter(64'd3);
      send_counter(64'h8000_0000_0000_0000);
      wait_drained();
      write_csr(CSR_DIGITS, 64'd9);
      send_counter(64'd7);
      wait_drained();

      send_bursts(100, 1'b0);
      wait_drained();

      // Full 32-byte all-ones key, one digit
      set_key('1, '1, '1, '1, 6'd32, 4'd1);
      send_bursts(100, 1'b0);
      wait_drained();

      // Length above the limit saturates to the 32-byte key register
      set_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, 6'd63, 4'd8);
      send_bursts(100, 1'b0);
      wait_drained();

      // Empty key, digits above nine
      write_csr(CSR_KEYLEN, 64'd0);
      write_csr(CSR_DIGITS, 64'd12);
      send_bursts(80, 1'b0);
      wait_drained();

      // Receiver holds off while counters keep coming so the pipeline backs up
      set_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, 6'd20, 4'd6);
      hold_request = 1'b1;
      send_bursts(300, 1'b1);
      wait_drained();

      // Random keys and settings, with a mid-phase pause until everything is back
      for (int p = 0; p < 4; p++) begin
         set_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, 6'($urandom_range(0, 40)),
                 4'($urandom_range(0, 15)));
         send_bursts(30, 1'b0);
         wait_drained();
         send_bursts(30, 1'b0);
         wait_drained();
      end

      // Drain, allow for latency, then report
      wait_drained();
      repeat (250) @(negedge clock);
      sb.mismatches += sb.pending_pw.size();
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/hotp_pkg.sv
design/hotp_key_sched.sv
design/hotp_sha1_pipe.sv
design/hotp_trunc_mod.sv
design/hotp_code_generator.sv
bench/tb_top.sv
